@@ hw/rtl/hktp_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, result codes and controller/datapath interface types for the key table probe
package hktp_pkg;

  localparam int KEY_W           = 64;
  localparam int OWNER_W         = 64;
  localparam int STATUS_W        = 3;
  localparam int SLOT_IDX_W      = 8;
  localparam int TABLE_SLOTS_DEF = 256;

  // start slot mix
  localparam logic [KEY_W-1:0] MIX_MULT  = 64'hff51afd7ed558ccd;
  localparam int               MIX_SHIFT = 33;

  // serial reduction for a table size that is not a power of two
  localparam int RED_BITS  = 4;
  localparam int RED_STEPS = KEY_W / RED_BITS;
  localparam int RED_CNT_W = $clog2(RED_STEPS + 1);

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

  typedef struct packed {
    logic                clr_wr;    // clear one used mark after reset
    logic                load;      // capture the input item
    logic                mul_step;  // one partial product of the mix
    logic                hash_fin;  // final xor-shift, start reduction
    logic                red_step;  // reduce a group of hash bits
    logic                idx_load;  // load start slot, clear probe count
    logic                rd;        // read the slot at the probe index
    logic                adv;       // move to the next slot
    logic                ins_wr;    // claim the probed slot
    logic                res_ld;    // load the result register
    logic [STATUS_W-1:0] res_code;
    logic                res_idx;   // report the probe index, else zero
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic invalid;
    logic insert;
    logic mul_done;
    logic red_done;
    logic used;
    logic key_eq;
    logic owner_eq;
    logic last;
  } sts_t;

endpackage

@@ hw/rtl/hashed_key_table_probe_top.sv @@
`timescale 1ns / 1ps
// top level of the hashed key table with linear probing
//
//  channel  direction  ports                                     handshake
//  in       input      in_func, in_item_key, in_owner_tag        in_valid / in_stall
//  out      output     out_status, out_slot_index                out_valid / out_stall
//
// sequence: the mix, then per probe one slot read and compare on the single slot
//   memory port; for a table size that is not a power of two the mix is followed
//   by a serial remainder; an invalid item ends before the mix
// reset: after rst_n the used marks are cleared one slot per cycle, with in_stall high
// stalls: a finished result waits in the output register while the next item is taken;
//   an item only stalls at its end while that register is still held
module hashed_key_table_probe_top #(
  parameter int TABLE_SLOTS = hktp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [hktp_pkg::KEY_W-1:0]       in_item_key,
  input  logic [hktp_pkg::OWNER_W-1:0]     in_owner_tag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hktp_pkg::STATUS_W-1:0]    out_status,
  output logic [hktp_pkg::SLOT_IDX_W-1:0]  out_slot_index
);

  hktp_pkg::cmd_t cmd;
  hktp_pkg::sts_t sts;

  hktp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  hktp_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_item_key    (in_item_key),
    .in_owner_tag   (in_owner_tag),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

endmodule

@@ hw/rtl/hktp_dp.sv @@
`timescale 1ns / 1ps
// datapath: key mix, slot reduction, slot memories, compare and result register
module hktp_dp #(
  parameter int TABLE_SLOTS = hktp_pkg::TABLE_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hktp_pkg::cmd_t                     cmd,
  output hktp_pkg::sts_t                     sts,
  input  logic                               in_func,
  input  logic [hktp_pkg::KEY_W-1:0]         in_item_key,
  input  logic [hktp_pkg::OWNER_W-1:0]       in_owner_tag,
  output logic [hktp_pkg::STATUS_W-1:0]      out_status,
  output logic [hktp_pkg::SLOT_IDX_W-1:0]    out_slot_index
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam logic [IDX_W:0]   SLOTS_W   = (IDX_W + 1)'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam int HALF_W = hktp_pkg::KEY_W / 2;

  // captured item
  logic                              func_r;
  logic [hktp_pkg::KEY_W-1:0]        key_r;
  logic [hktp_pkg::OWNER_W-1:0]      owner_r;
  logic [hktp_pkg::KEY_W-1:0]        mix_a_r;

  // mix multiply
  logic [2:0]                        mul_cnt_r;
  logic [HALF_W-1:0]                 opa;
  logic [HALF_W-1:0]                 opb;
  logic [hktp_pkg::KEY_W-1:0]        prod_r;
  logic [hktp_pkg::KEY_W-1:0]        acc_r;

  // reduction
  logic [hktp_pkg::KEY_W-1:0]        hash_r;
  logic [IDX_W-1:0]                  rem_r;
  logic [IDX_W-1:0]                  rem_nxt;
  logic [hktp_pkg::RED_CNT_W-1:0]    red_cnt_r;

  // probing
  logic [IDX_W-1:0]                  idx_r;
  logic [IDX_W-1:0]                  cnt_r;
  logic [IDX_W-1:0]                  clr_addr_r;

  // slot stores
  logic                              used_mem  [TABLE_SLOTS];
  logic [hktp_pkg::KEY_W-1:0]        key_mem   [TABLE_SLOTS];
  logic [hktp_pkg::OWNER_W-1:0]      owner_mem [TABLE_SLOTS];
  logic                              rd_used_r;
  logic [hktp_pkg::KEY_W-1:0]        rd_key_r;
  logic [hktp_pkg::OWNER_W-1:0]      rd_owner_r;

  logic [hktp_pkg::STATUS_W-1:0]     out_status_r;
  logic [hktp_pkg::SLOT_IDX_W-1:0]   out_slot_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      key_r   <= in_item_key;
      owner_r <= in_owner_tag;
      mix_a_r <= in_item_key ^ (in_item_key >> hktp_pkg::MIX_SHIFT);
    end
  end

  // low 64 bits of the product from three 32x32 partial products
  always_comb begin
    case (mul_cnt_r)
      3'd0: begin
        opa = mix_a_r[HALF_W-1:0];
        opb = hktp_pkg::MIX_MULT[HALF_W-1:0];
      end
      3'd1: begin
        opa = mix_a_r[HALF_W-1:0];
        opb = hktp_pkg::MIX_MULT[hktp_pkg::KEY_W-1:HALF_W];
      end
      default: begin
        opa = mix_a_r[hktp_pkg::KEY_W-1:HALF_W];
        opb = hktp_pkg::MIX_MULT[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (cmd.load) begin
      mul_cnt_r <= '0;
    end else if (cmd.mul_step) begin
      mul_cnt_r <= mul_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      prod_r <= opa * opb;
      if (mul_cnt_r == 3'd1) begin
        acc_r <= prod_r;
      end else if (mul_cnt_r != 3'd0) begin
        acc_r[hktp_pkg::KEY_W-1:HALF_W] <= acc_r[hktp_pkg::KEY_W-1:HALF_W] +
                                           prod_r[HALF_W-1:0];
      end
    end
  end

  // restoring remainder, a group of hash bits per cycle
  always_comb begin
    logic [IDX_W:0] t;
    rem_nxt = rem_r;
    for (int j = 0; j < hktp_pkg::RED_BITS; j++) begin
      t = {rem_nxt, hash_r[hktp_pkg::KEY_W-1-j]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      rem_nxt = t[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_fin) begin
      hash_r <= acc_r ^ (acc_r >> hktp_pkg::MIX_SHIFT);
      rem_r  <= '0;
    end else if (cmd.red_step) begin
      hash_r <= hash_r << hktp_pkg::RED_BITS;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_cnt_r <= '0;
    end else if (cmd.hash_fin) begin
      red_cnt_r <= '0;
    end else if (cmd.red_step) begin
      red_cnt_r <= red_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      idx_r <= IS_POW2 ? hash_r[IDX_W-1:0] : rem_r;
      cnt_r <= '0;
    end else if (cmd.adv) begin
      idx_r <= (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr && (clr_addr_r != LAST_SLOT)) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      used_mem[clr_addr_r] <= 1'b0;
    end else if (cmd.ins_wr) begin
      used_mem[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) begin
      key_mem[idx_r]   <= key_r;
      owner_mem[idx_r] <= owner_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_used_r  <= used_mem[idx_r];
      rd_key_r   <= key_mem[idx_r];
      rd_owner_r <= owner_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_status_r <= cmd.res_code;
      out_slot_r   <= cmd.res_idx ? hktp_pkg::SLOT_IDX_W'(idx_r) : '0;
    end
  end

  assign sts.clr_last = (clr_addr_r == LAST_SLOT);
  assign sts.invalid  = (key_r == '0) || (func_r && (owner_r == '0));
  assign sts.insert   = func_r;
  assign sts.mul_done = (mul_cnt_r == 3'd4);
  assign sts.red_done = IS_POW2 || (red_cnt_r == hktp_pkg::RED_CNT_W'(hktp_pkg::RED_STEPS));
  assign sts.used     = rd_used_r;
  assign sts.key_eq   = (rd_key_r == key_r);
  assign sts.owner_eq = (rd_owner_r == owner_r);
  assign sts.last     = (cnt_r == LAST_SLOT);

  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

endmodule

@@ hw/rtl/hktp_ctrl.sv @@
`timescale 1ns / 1ps
// controller: clearing pass, mix sequencing, probe walk and result handshake
module hktp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output hktp_pkg::cmd_t cmd,
  input  hktp_pkg::sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHKV  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_RED   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHKV;
        end
      end
      S_CHKV: begin
        if (!sts.invalid) begin
          state_nxt = S_MUL;
        end else if (out_free) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = hktp_pkg::ST_INVALID;
          state_nxt    = S_IDLE;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.hash_fin = 1'b1;
          state_nxt    = S_RED;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_RED: begin
        if (sts.red_done) begin
          cmd.idx_load = 1'b1;
          state_nxt    = S_READ;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.used) begin
          // empty slot ends the walk
          if (out_free) begin
            cmd.res_ld = 1'b1;
            if (sts.insert) begin
              cmd.ins_wr   = 1'b1;
              cmd.res_code = hktp_pkg::ST_INSERTED;
              cmd.res_idx  = 1'b1;
            end else begin
              cmd.res_code = hktp_pkg::ST_MISS;
            end
            state_nxt = S_IDLE;
          end
        end else if (sts.key_eq) begin
          if (out_free) begin
            cmd.res_ld = 1'b1;
            if (sts.insert && !sts.owner_eq) begin
              cmd.res_code = hktp_pkg::ST_MISMATCH;
            end else begin
              cmd.res_code = hktp_pkg::ST_FOUND;
              cmd.res_idx  = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end else if (sts.last) begin
          // walked every slot
          if (out_free) begin
            cmd.res_ld   = 1'b1;
            cmd.res_code = sts.insert ? hktp_pkg::ST_FULL : hktp_pkg::ST_MISS;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_res_ld_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> out_free)
    else $error("result loaded over an untaken item");

  a_ins_has_res : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> (cmd.res_ld && sts.insert && !sts.used))
    else $error("slot claimed without an empty slot or a result");

  a_adv_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> (!sts.last && sts.used && !sts.key_eq))
    else $error("probe walked past the table");

  a_res_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> out_valid_r)
    else $error("loaded result not presented");

endmodule
